[rtl/packet_sequence_reorder_buffer_macros.svh]
// Assertion macros for the packet sequence reorder buffer.
`ifndef PACKET_SEQUENCE_REORDER_BUFFER_MACROS_SVH
`define PACKET_SEQUENCE_REORDER_BUFFER_MACROS_SVH

// Overlapping implication on the same edge.
`define PSRB_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Implication on the next edge.
`define PSRB_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

[rtl/psrb_pkg.sv]
// ----------------------------------------------------------------------------
// psrb_pkg
// Types, constants and helpers shared by the packet sequence reorder buffer.
// ----------------------------------------------------------------------------
package psrb_pkg;

   localparam int SLOT_COUNT      = 32;
   localparam int SLOT_BITS       = $clog2(SLOT_COUNT);
   localparam int TS_PACKET_BYTES = 188;

   // 188 is 4 times 47. These are the inverse of 47 modulo 2^14 and the
   // largest multiple count of 47 below 2^14.
   localparam logic [13:0] TS_ODD_INVERSE = 14'd1743;
   localparam logic [13:0] TS_ODD_LIMIT   = 14'd348;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [2:0] EV_STORED    = 3'd0;
   localparam logic [2:0] EV_DUPLICATE = 3'd1;
   localparam logic [2:0] EV_FULL      = 3'd2;
   localparam logic [2:0] EV_STALE     = 3'd3;
   localparam logic [2:0] EV_BEYOND    = 3'd4;
   localparam logic [2:0] EV_RELEASED  = 3'd5;
   localparam logic [2:0] EV_EXPIRED   = 3'd6;
   localparam logic [2:0] EV_DONE      = 3'd7;

   localparam logic [1:0] CSR_MAX_BYTES  = 2'd0;
   localparam logic [1:0] CSR_WINDOW     = 2'd1;
   localparam logic [1:0] CSR_KF_ENABLE  = 2'd2;
   localparam logic [1:0] CSR_KF_RELAX   = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [31:0] seq_num;
      logic [15:0] pkt_length;
      logic [31:0] arrival_ms;
      logic        keyframe_in;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] seq_out;
      logic [15:0] length_out;
      logic        keyframe_out;
      logic        whole_ts_out;
      logic        last;
      logic [31:0] duplicates_seen;
      logic [31:0] dropped_seen;
      logic [31:0] stale_seen;
      logic [23:0] bytes_held;
   } rsp_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // Multiple of 188 test: the length must be a multiple of 4, and its upper
   // bits times the inverse of 47 land at or below the limit exactly for
   // multiples of 47.
   function automatic logic is_whole_ts(input logic [15:0] len);
      logic [13:0] folded;
      folded = len[15:2] * TS_ODD_INVERSE;
      return (len[1:0] == 2'b00) && (folded <= TS_ODD_LIMIT);
   endfunction

endpackage

[rtl/psrb_channel_if.sv]
// ----------------------------------------------------------------------------
// psrb_channel_if
// Valid/ready channel that carries one word of a given payload type.
// ----------------------------------------------------------------------------
interface psrb_channel_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/packet_sequence_reorder_buffer.sv]
// An accepted word passes through the read and evaluate states; evaluate writes the
// output register, stalling while it holds a word not yet taken. A drain repeats
// read and evaluate for each ready entry and ends with a done word.
// Each word waits in the output register until taken; no new word is accepted
// until the last word of the current one is taken.
// Reset clears valid bits, counters and state; slot, item and output data stay.
// ----------------------------------------------------------------------------
// packet_sequence_reorder_buffer
// Reorders packet descriptors by sequence number in a slot memory.
// ----------------------------------------------------------------------------
`include "packet_sequence_reorder_buffer_macros.svh"

module packet_sequence_reorder_buffer
   import psrb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   psrb_channel_if.sink        req,
   psrb_channel_if.source      rsp,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [23:0]         csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_EVAL  = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;

   logic [2:0]  state_ff, state_in;
   req_type     item_ff, item_in;
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   logic        more_ff, more_in;

   logic [23:0] max_bytes_ff;
   logic [15:0] window_ff, relax_ff;
   logic        kf_enable_ff;

   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic [31:0] expected_ff, expected_in;
   logic [23:0] held_ff, held_in;
   logic [31:0] dup_ff, dup_in, drop_ff, drop_in, stale_ff, stale_in;

   logic [31:0] mem_seq [SLOT_COUNT];
   logic [15:0] mem_len [SLOT_COUNT];
   logic [31:0] mem_time [SLOT_COUNT];
   logic        mem_kf [SLOT_COUNT];

   logic [31:0] rd_seq_ff, rd_time_ff;
   logic [15:0] rd_len_ff;
   logic        rd_kf_ff;
   logic [SLOT_BITS-1:0] rd_addr;
   logic        wr_en;
   logic [SLOT_BITS-1:0] wr_addr;

   logic [SLOT_BITS-1:0] slot;
   logic        hit, over, empty, stale, beyond, expired;
   logic [31:0] exp_eff, age;
   logic [16:0] allowed;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= 24'd1048576;
         window_ff    <= 16'd200;
         kf_enable_ff <= 1'b0;
         relax_ff     <= 16'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_BYTES: max_bytes_ff <= csr_data;
            CSR_WINDOW:    window_ff    <= csr_data[15:0];
            CSR_KF_ENABLE: kf_enable_ff <= csr_data[0];
            CSR_KF_RELAX:  relax_ff     <= csr_data[15:0];
         endcase
      end
   end

   assign rd_addr = (item_ff.opcode == OP_DRAIN) ? expected_ff[SLOT_BITS-1:0]
                                                 : item_ff.seq_num[SLOT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_seq[wr_addr]  <= item_ff.seq_num;
         mem_len[wr_addr]  <= item_ff.pkt_length;
         mem_time[wr_addr] <= item_ff.arrival_ms;
         mem_kf[wr_addr]   <= item_ff.keyframe_in;
      end
      rd_seq_ff  <= mem_seq[rd_addr];
      rd_len_ff  <= mem_len[rd_addr];
      rd_time_ff <= mem_time[rd_addr];
      rd_kf_ff   <= mem_kf[rd_addr];
   end

   assign slot    = rd_addr;
   assign empty   = (valid_ff == '0);
   assign hit     = valid_ff[slot] && (rd_seq_ff == ((item_ff.opcode == OP_DRAIN)
                                                     ? expected_ff : item_ff.seq_num));
   assign over    = ({1'b0, held_ff} + 25'(item_ff.pkt_length)) > {1'b0, max_bytes_ff};
   assign exp_eff = (expected_ff == 32'd0 && empty) ? item_ff.seq_num : expected_ff;
   assign stale   = item_ff.seq_num < exp_eff;
   assign beyond  = {1'b0, item_ff.seq_num} >= ({1'b0, exp_eff} + 33'(SLOT_COUNT));
   assign age     = item_ff.now_ms - rd_time_ff;
   assign allowed = {1'b0, window_ff} + ((kf_enable_ff && rd_kf_ff) ? {1'b0, relax_ff}
                                                                    : 17'd0);
   assign expired = !age[31] && (age > 32'(allowed));

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      more_in      = more_ff;
      valid_in     = valid_ff;
      expected_in  = expected_ff;
      held_in      = held_ff;
      dup_in       = dup_ff;
      drop_in      = drop_ff;
      stale_in     = stale_ff;
      wr_en        = 1'b0;
      wr_addr      = slot;
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               item_in  = req.payload;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               state_in     = ST_WAIT;
               more_in      = 1'b0;
               if (item_ff.opcode == OP_ADD) begin
                  out_in.seq_out      = item_ff.seq_num;
                  out_in.length_out   = item_ff.pkt_length;
                  out_in.keyframe_out = item_ff.keyframe_in;
                  out_in.whole_ts_out = is_whole_ts(item_ff.pkt_length);
                  out_in.last         = 1'b1;
                  if (hit) begin
                     dup_in           = sat_inc(dup_ff);
                     out_in.event_res = EV_DUPLICATE;
                  end else if (over) begin
                     drop_in          = sat_inc(drop_ff);
                     out_in.event_res = EV_FULL;
                  end else begin
                     expected_in = exp_eff;
                     if (stale) begin
                        stale_in         = sat_inc(stale_ff);
                        out_in.event_res = EV_STALE;
                     end else if (beyond) begin
                        out_in.event_res = EV_BEYOND;
                     end else begin
                        wr_en          = 1'b1;
                        valid_in[slot] = 1'b1;
                        held_in = (valid_ff[slot] ? held_ff - 24'(rd_len_ff) : held_ff)
                                  + 24'(item_ff.pkt_length);
                        out_in.event_res = EV_STORED;
                     end
                  end
               end else if (hit) begin
                  more_in             = 1'b1;
                  valid_in[slot]      = 1'b0;
                  held_in             = held_ff - 24'(rd_len_ff);
                  expected_in         = expected_ff + 32'd1;
                  out_in.seq_out      = rd_seq_ff;
                  out_in.length_out   = rd_len_ff;
                  out_in.keyframe_out = rd_kf_ff;
                  out_in.whole_ts_out = is_whole_ts(rd_len_ff);
                  out_in.last         = 1'b0;
                  if (expired) begin
                     drop_in          = sat_inc(drop_ff);
                     out_in.event_res = EV_EXPIRED;
                  end else begin
                     out_in.event_res = EV_RELEASED;
                  end
               end else begin
                  out_in.event_res    = EV_DONE;
                  out_in.seq_out      = expected_ff;
                  out_in.length_out   = 16'd0;
                  out_in.keyframe_out = 1'b0;
                  out_in.whole_ts_out = 1'b0;
                  out_in.last         = 1'b1;
               end
               out_in.duplicates_seen = dup_in;
               out_in.dropped_seen    = drop_in;
               out_in.stale_seen      = stale_in;
               out_in.bytes_held      = held_in;
            end
         end
         ST_WAIT: begin
            if (more_ff) begin
               state_in = ST_READ;
            end else if (!out_valid_ff || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         more_ff      <= 1'b0;
         valid_ff     <= '0;
         expected_ff  <= '0;
         held_ff      <= '0;
         dup_ff       <= '0;
         drop_ff      <= '0;
         stale_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         more_ff      <= more_in;
         valid_ff     <= valid_in;
         expected_ff  <= expected_in;
         held_ff      <= held_in;
         dup_ff       <= dup_in;
         drop_ff      <= drop_in;
         stale_ff     <= stale_in;
      end
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   `PSRB_ASSERT_IMP(a_ready_idle, clock, reset, req.ready, !out_valid_ff || state_ff == ST_IDLE,
                    "ready outside idle")
   `PSRB_ASSERT_NEXT(a_read_eval, clock, reset, state_ff == ST_READ, state_ff == ST_EVAL,
                     "read not followed by evaluate")
   `PSRB_ASSERT_NEXT(a_drop_mono, clock, reset, 1'b1, drop_ff >= $past(drop_ff),
                     "drop count decreased")
   `PSRB_ASSERT_IMP(a_idle_done, clock, reset, state_ff == ST_IDLE && out_valid_ff,
                    out_ff.last, "pending word in idle is not the last")

endmodule

[tb/sv/psrb_order_checker.sv]
// ----------------------------------------------------------------------------
// psrb_order_checker
// Watches the request, response and register ports of the reorder buffer,
// keeps its own slot model to predict every response word, and compares each
// taken response word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module psrb_order_checker
   import psrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_word,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_word,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data,
   output int          mismatch_count,
   output int          words_outstanding,
   output logic [31:0] next_expected
);

   logic [23:0] budget_bytes;
   logic [15:0] window_ms;
   logic        relax_on;
   logic [15:0] relax_ms;

   logic        held_valid [SLOT_COUNT];
   logic [31:0] held_seq [SLOT_COUNT];
   logic [15:0] held_len [SLOT_COUNT];
   logic [31:0] held_time [SLOT_COUNT];
   logic        held_kf [SLOT_COUNT];
   logic [31:0] expect_seq;
   logic [23:0] held_total;
   logic [31:0] dup_total;
   logic [31:0] drop_total;
   logic [31:0] stale_total;

   rsp_type predicted_words [$];

   assign words_outstanding = predicted_words.size();
   assign next_expected = expect_seq;

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic rsp_type make_word(input logic [2:0] ev, input logic [31:0] seq,
                                         input logic [15:0] len, input logic kf,
                                         input logic whole, input logic fin);
      rsp_type w;
      w.event_res = ev;
      w.seq_out = seq;
      w.length_out = len;
      w.keyframe_out = kf;
      w.whole_ts_out = whole;
      w.last = fin;
      w.duplicates_seen = dup_total;
      w.dropped_seen = drop_total;
      w.stale_seen = stale_total;
      w.bytes_held = held_total;
      return w;
   endfunction

   task automatic append_word(input rsp_type w);
      predicted_words = {predicted_words, w};
   endtask

   task automatic predict_word(input req_type r);
      int unsigned s;
      logic [2:0] ev;
      logic empty;
      logic [31:0] age;
      logic [16:0] allowed;
      int n;
      if (r.opcode == OP_ADD) begin
         s = r.seq_num % SLOT_COUNT;
         empty = 1'b1;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (held_valid[i]) empty = 1'b0;
         end
         if (held_valid[s] && held_seq[s] == r.seq_num) begin
            dup_total = bump(dup_total);
            ev = EV_DUPLICATE;
         end else if ({1'b0, held_total} + 25'(r.pkt_length) > {1'b0, budget_bytes}) begin
            drop_total = bump(drop_total);
            ev = EV_FULL;
         end else begin
            if (expect_seq == 32'd0 && empty) expect_seq = r.seq_num;
            if (r.seq_num < expect_seq) begin
               stale_total = bump(stale_total);
               ev = EV_STALE;
            end else if ({1'b0, r.seq_num} >= {1'b0, expect_seq} + 33'(SLOT_COUNT)) begin
               ev = EV_BEYOND;
            end else begin
               if (held_valid[s]) held_total = held_total - 24'(held_len[s]);
               held_valid[s] = 1'b1;
               held_seq[s] = r.seq_num;
               held_len[s] = r.pkt_length;
               held_time[s] = r.arrival_ms;
               held_kf[s] = r.keyframe_in;
               held_total = held_total + 24'(r.pkt_length);
               ev = EV_STORED;
            end
         end
         append_word(make_word(ev, r.seq_num, r.pkt_length, r.keyframe_in,
                               (r.pkt_length % TS_PACKET_BYTES) == 0, 1'b1));
      end else begin
         n = 0;
         while (n < SLOT_COUNT) begin
            s = expect_seq % SLOT_COUNT;
            if (!held_valid[s] || held_seq[s] != expect_seq) break;
            age = r.now_ms - held_time[s];
            allowed = 17'(window_ms);
            if (relax_on && held_kf[s]) allowed = allowed + 17'(relax_ms);
            if (!age[31] && age > 32'(allowed)) begin
               drop_total = bump(drop_total);
               ev = EV_EXPIRED;
            end else begin
               ev = EV_RELEASED;
            end
            held_valid[s] = 1'b0;
            held_total = held_total - 24'(held_len[s]);
            append_word(make_word(ev, held_seq[s], held_len[s], held_kf[s],
                                  (held_len[s] % TS_PACKET_BYTES) == 0, 1'b0));
            n++;
            expect_seq = expect_seq + 32'd1;
         end
         append_word(make_word(EV_DONE, expect_seq, 16'd0, 1'b0, 1'b0, 1'b1));
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         budget_bytes = 24'd1048576;
         window_ms = 16'd200;
         relax_on = 1'b0;
         relax_ms = 16'd0;
         for (int i = 0; i < SLOT_COUNT; i++) held_valid[i] = 1'b0;
         expect_seq = '0;
         held_total = '0;
         dup_total = '0;
         drop_total = '0;
         stale_total = '0;
         predicted_words.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected response word %p", rsp_word);
            end else begin
               want = predicted_words.pop_front();
               if (want.event_res !== rsp_word.event_res || want.seq_out !== rsp_word.seq_out ||
                   want.length_out !== rsp_word.length_out ||
                   want.keyframe_out !== rsp_word.keyframe_out ||
                   want.whole_ts_out !== rsp_word.whole_ts_out ||
                   want.last !== rsp_word.last ||
                   want.duplicates_seen !== rsp_word.duplicates_seen ||
                   want.dropped_seen !== rsp_word.dropped_seen ||
                   want.stale_seen !== rsp_word.stale_seen ||
                   want.bytes_held !== rsp_word.bytes_held) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Response word differs: expected %p actual %p", want, rsp_word);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAX_BYTES: budget_bytes = csr_data;
               CSR_WINDOW: window_ms = csr_data[15:0];
               CSR_KF_ENABLE: relax_on = csr_data[0];
               CSR_KF_RELAX: relax_ms = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_word(req_word);
      end
   end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives the reorder buffer with directed and random add and drain words over
// several register settings and idle patterns, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import psrb_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_MAX_BYTES;
   logic [23:0] csr_data = '0;
   int          mismatch_count;
   int          words_outstanding;
   logic [31:0] next_expected;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_cycles = 0;
   logic        hold_go = 1'b0;
   logic        hold_done = 1'b0;
   logic [31:0] clock_ms = 32'd5000;

   psrb_channel_if #(.payload_type(req_type)) req_ch ();
   psrb_channel_if #(.payload_type(rsp_type)) rsp_ch ();

   packet_sequence_reorder_buffer u_top (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   psrb_order_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_word(req_ch.payload),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_word(rsp_ch.payload),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatch_count(mismatch_count),
      .words_outstanding(words_outstanding),
      .next_expected(next_expected)
   );

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // The long receiver hold counts its cycles here, once it is requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (hold_go && !hold_done) begin
         hold_cycles <= 300;
         hold_done <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_word(input req_type w);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic offer_packet(input logic [31:0] seq, input logic [15:0] len,
                               input logic [31:0] arr, input logic kf);
      req_type w;
      w = '0;
      w.opcode = OP_ADD;
      w.seq_num = seq;
      w.pkt_length = len;
      w.arrival_ms = arr;
      w.keyframe_in = kf;
      w.now_ms = $urandom;
      send_word(w);
   endtask

   task automatic drain_at(input logic [31:0] now);
      req_type w;
      w = '0;
      w.opcode = OP_DRAIN;
      w.seq_num = $urandom;
      w.pkt_length = $urandom;
      w.arrival_ms = $urandom;
      w.keyframe_in = $urandom;
      w.now_ms = now;
      send_word(w);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_idle;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (words_outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_length;
      int r;
      r = $urandom_range(99);
      if (r < 10) return 16'd0;
      if (r < 25) return 16'(TS_PACKET_BYTES * $urandom_range(10, 1));
      if (r < 30) return 16'hFFFF;
      if (r < 35) return 16'($urandom);
      return 16'($urandom_range(2000));
   endfunction

   task automatic random_phase(input int item_total, inout int sent);
      logic [31:0] base;
      int k;
      int order [8];
      int tmp;
      int j;
      int skip;
      logic [31:0] seq;
      while (sent < item_total) begin
         if ($urandom_range(99) < 75) begin
            @(negedge clock);
            base = next_expected;
            if (base == 32'd0) base = $urandom;
            k = $urandom_range(8, 1);
            for (int i = 0; i < 8; i++) order[i] = i;
            for (int i = 0; i < k; i++) begin
               j = $urandom_range(k - 1);
               tmp = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            skip = ($urandom_range(9) == 0) ? $urandom_range(k - 1) : -1;
            for (int i = 0; i < k; i++) begin
               if (order[i] != skip) begin
                  seq = base + 32'(order[i]);
                  offer_packet(seq, pick_length(), clock_ms - 32'($urandom_range(300)),
                               $urandom);
                  sent++;
                  if ($urandom_range(19) == 0) begin
                     offer_packet(seq, pick_length(), clock_ms, $urandom);
                     sent++;
                  end
               end
            end
            clock_ms = clock_ms + 32'($urandom_range(150));
            drain_at(clock_ms + 32'($urandom_range(250)));
            sent++;
         end else begin
            case ($urandom_range(3))
               0: offer_packet($urandom, $urandom, $urandom, $urandom);
               1: offer_packet(next_expected - 32'($urandom_range(5, 1)), pick_length(),
                               clock_ms, $urandom);
               2: offer_packet(next_expected + 32'($urandom_range(40, 30)), pick_length(),
                               clock_ms, $urandom);
               default: drain_at($urandom);
            endcase
            sent++;
         end
      end
   endtask

   initial begin
      int sent;
      sent = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sequence numbers that wrap past the top, duplicates, stale words,
      // a drain that expires every entry, and a drain with nothing ready.
      offer_packet(32'hFFFF_FFF8, 16'd188, 32'd0, 1'b1);
      offer_packet(32'hFFFF_FFF8, 16'd188, 32'd0, 1'b1);
      offer_packet(32'hFFFF_FFF0, 16'd10, 32'd0, 1'b0);
      offer_packet(32'hFFFF_FFF9, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      offer_packet(32'hFFFF_FFFA, 16'd0, 32'd100, 1'b1);
      drain_at(32'd50);
      for (int i = 11; i <= 15; i++) offer_packet(32'hFFFF_FFF0 + 32'(i), 16'd376, 32'd0, 1'b1);
      drain_at(32'd300);
      offer_packet(32'd1000, 16'd500, 32'd1000, 1'b1);
      offer_packet(32'd1032, 16'd5, 32'd1000, 1'b0);
      offer_packet(32'd999, 16'd5, 32'd1000, 1'b0);
      offer_packet(32'd1001, 16'd189, 32'd1200, 1'b0);
      drain_at(32'd1200);
      drain_at(32'd1200);
      drain_at(32'h8000_0000);

      random_phase(60, sent);
      hold_go <= 1'b1;
      random_phase(100, sent);
      wait_idle();

      write_reg(CSR_MAX_BYTES, 24'hFF_FFFF);
      write_reg(CSR_WINDOW, 24'd0);
      write_reg(CSR_KF_ENABLE, 24'd1);
      write_reg(CSR_KF_RELAX, 24'hFFFF);
      send_idle_pct = 53;
      random_phase(190, sent);
      wait_idle();

      write_reg(CSR_MAX_BYTES, 24'd3000);
      write_reg(CSR_WINDOW, 24'hFFFF);
      write_reg(CSR_KF_ENABLE, 24'd0);
      write_reg(CSR_KF_RELAX, 24'd0);
      send_idle_pct = 0;
      stall_pct = 53;
      random_phase(280, sent);
      wait_idle();

      write_reg(CSR_MAX_BYTES, 24'd0);
      write_reg(CSR_WINDOW, 24'd100);
      write_reg(CSR_KF_ENABLE, 24'd1);
      write_reg(CSR_KF_RELAX, 24'd50);
      send_idle_pct = 28;
      stall_pct = 28;
      random_phase(310, sent);
      wait_idle();

      write_reg(CSR_MAX_BYTES, 24'd20000);
      random_phase(350, sent);
      wait_idle();

      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && words_outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
